>>> design/pgws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgws_pkg - shared types and constants of the pheromone grid walker
// Map geometry, cell kinds, op and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package pgws_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int RADIUS   = 1;

  // item coordinates are fixed at 6 bits
  localparam int ROW_W    = 6;
  localparam int CFG_W    = 7;
  localparam int GAIN_W   = 16;
  localparam int LVL_W    = 16;
  localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;

  // usable grid limit per dimension
  localparam int ROW_LIM  = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int COL_LIM  = (MAX_COLS < 64) ? MAX_COLS : 64;

  localparam int SPAN     = 2 * RADIUS + 1;
  localparam int NBR_MAX  = SPAN * SPAN - 1;
  localparam int NBR_IW   = $clog2(NBR_MAX);
  localparam int NBR_CW   = $clog2(NBR_MAX + 1);
  localparam int OFS_W    = 3;
  localparam int WGT_W    = LVL_W + 1;
  localparam int TOT_W    = WGT_W + $clog2(NBR_MAX);
  localparam int PROD_W   = WGT_W + GAIN_W;
  localparam int RT_W     = TOT_W + GAIN_W;

  localparam logic [1:0] KIND_FREE    = 2'd0;
  localparam logic [1:0] KIND_WALL    = 2'd1;
  localparam logic [1:0] KIND_VISITED = 2'd2;
  localparam logic [1:0] KIND_ROBOT   = 2'd3;

  localparam logic [1:0] REG_ROWS     = 2'd0;
  localparam logic [1:0] REG_COLS     = 2'd1;
  localparam logic [1:0] REG_NGAIN    = 2'd2;
  localparam logic [1:0] REG_SGAIN    = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PLACE = 2'd1,
    OP_MOVE  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MOVED   = 2'd1,
    ST_BLOCKED = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic exec;
    logic nb_read;
    logic nb_next;
    logic mul;
    logic mul_self;
    logic nb_write;
    logic self_read;
    logic self_write;
    logic mul_rt;
    logic sel_step;
    logic mark_old;
    logic mark_new;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic nb_valid;
    logic nb_last;
    logic is_wall;
    logic n_zero;
    logic sel_hit;
  } stat_t;

endpackage

>>> design/pheromone_grid_walk_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pheromone_grid_walk_step_top - ant-style pheromone grid walker
// Map writes, walker placement and roulette-wheel moves on a cell grid.
// ----------------------------------------------------------------------------
// Map write / place / nop: the word is executed, then the output word loaded.
// A move visits each window offset; each in-grid non-wall neighbor gets a
// deposit multiply and write back, then the own cell does too. If a neighbor
// was kept, the pick is set up, neighbors scanned, cells marked. Output word
// loaded last. One word in work at a time. Reset: a clearing pass writes all
// 4096 cells of both maps, no word taken until it ends; config always taken.
module pheromone_grid_walk_step_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_row[5:0], cell_col[11:6], cell_kind[13:12], random_value[29:14]
  input  logic [31:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pos_row[5:0], pos_col[11:6], status[13:12]
  output logic [15:0] m_axis_tdata
);

  pgws_pkg::cmd_t  cmd;
  pgws_pkg::stat_t stat;
  logic [5:0] pos_row, pos_col;
  logic [1:0] status;

  pgws_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_op_i(s_axis_tuser),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd)
  );

  pgws_dp u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_op_i(s_axis_tuser),
    .in_row_i(s_axis_tdata[5:0]), .in_col_i(s_axis_tdata[11:6]),
    .in_kind_i(s_axis_tdata[13:12]), .in_rnd_i(s_axis_tdata[29:14]),
    .cmd_i(cmd), .stat_o(stat),
    .pos_row_o(pos_row), .pos_col_o(pos_col), .status_o(status)
  );

  assign m_axis_tdata = {2'b00, status, pos_col, pos_row};

endmodule

>>> design/pgws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgws_ram - generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module pgws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/pgws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgws_ctrl - sequencer of the grid walker
// Clears the maps after reset, then steps each word through its op.
// ----------------------------------------------------------------------------
module pgws_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pgws_pkg::stat_t stat_i,
  output pgws_pkg::cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_EXEC  = 14'b00000000000100,
    S_NRD   = 14'b00000000001000,
    S_NCHK  = 14'b00000000010000,
    S_NWR   = 14'b00000000100000,
    S_SRD   = 14'b00000001000000,
    S_SCHK  = 14'b00000010000000,
    S_SWR   = 14'b00000100000000,
    S_RND   = 14'b00001000000000,
    S_SEL   = 14'b00010000000000,
    S_MOLD  = 14'b00100000000000,
    S_MNEW  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (in_op_i == pgws_pkg::OP_MOVE) ? S_NRD : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_DONE;
      end
      S_NRD: begin
        if (stat_i.nb_valid) begin
          cmd_o.nb_read = 1'b1;
          state_d = S_NCHK;
        end else if (stat_i.nb_last) begin
          state_d = S_SRD;
        end else begin
          cmd_o.nb_next = 1'b1;
        end
      end
      S_NCHK: begin
        if (!stat_i.is_wall) begin
          cmd_o.mul = 1'b1;
          state_d = S_NWR;
        end else if (stat_i.nb_last) begin
          state_d = S_SRD;
        end else begin
          cmd_o.nb_next = 1'b1;
          state_d = S_NRD;
        end
      end
      S_NWR: begin
        cmd_o.nb_write = 1'b1;
        if (stat_i.nb_last) begin
          state_d = S_SRD;
        end else begin
          cmd_o.nb_next = 1'b1;
          state_d = S_NRD;
        end
      end
      S_SRD: begin
        cmd_o.self_read = 1'b1;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_self = 1'b1;
        state_d = S_SWR;
      end
      S_SWR: begin
        cmd_o.self_write = 1'b1;
        state_d = stat_i.n_zero ? S_DONE : S_RND;
      end
      S_RND: begin
        cmd_o.mul_rt = 1'b1;
        state_d = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel_step = 1'b1;
        if (stat_i.sel_hit) state_d = S_MOLD;
      end
      S_MOLD: begin
        cmd_o.mark_old = 1'b1;
        state_d = S_MNEW;
      end
      S_MNEW: begin
        cmd_o.mark_new = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("word accepted during clearing pass");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");
  a_move_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RND) |-> $past(state_q == S_SWR))
    else $error("selection entered without deposits");
`endif

endmodule

>>> design/pgws_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgws_dp - datapath of the grid walker
// Config registers, map RAMs, deposit multiplier, weights and selection.
// ----------------------------------------------------------------------------
module pgws_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [pgws_pkg::GAIN_W-1:0]  cfg_data_i,
  input  logic [1:0]                   in_op_i,
  input  logic [pgws_pkg::ROW_W-1:0]   in_row_i,
  input  logic [pgws_pkg::ROW_W-1:0]   in_col_i,
  input  logic [1:0]                   in_kind_i,
  input  logic [pgws_pkg::GAIN_W-1:0]  in_rnd_i,
  input  pgws_pkg::cmd_t               cmd_i,
  output pgws_pkg::stat_t              stat_o,
  output logic [pgws_pkg::ROW_W-1:0]   pos_row_o,
  output logic [pgws_pkg::ROW_W-1:0]   pos_col_o,
  output logic [1:0]                   status_o
);

  localparam int AW = pgws_pkg::ADDR_W;
  localparam int RW = pgws_pkg::ROW_W;
  localparam logic signed [pgws_pkg::OFS_W-1:0] RMAX = pgws_pkg::OFS_W'(pgws_pkg::RADIUS);
  localparam logic signed [pgws_pkg::OFS_W-1:0] RMIN = -RMAX;

  // configuration
  logic [pgws_pkg::CFG_W-1:0]  rows_q, cols_q;
  logic [pgws_pkg::GAIN_W-1:0] ngain_q, sgain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 7'd64;
      cols_q  <= 7'd64;
      ngain_q <= 16'd14299;
      sgain_q <= 16'd42598;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pgws_pkg::REG_ROWS:  rows_q  <= cfg_data_i[pgws_pkg::CFG_W-1:0];
        pgws_pkg::REG_COLS:  cols_q  <= cfg_data_i[pgws_pkg::CFG_W-1:0];
        pgws_pkg::REG_NGAIN: ngain_q <= cfg_data_i;
        pgws_pkg::REG_SGAIN: sgain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [pgws_pkg::CFG_W-1:0] ar, ac;
  assign ar = (rows_q > pgws_pkg::CFG_W'(pgws_pkg::ROW_LIM))
              ? pgws_pkg::CFG_W'(pgws_pkg::ROW_LIM) : rows_q;
  assign ac = (cols_q > pgws_pkg::CFG_W'(pgws_pkg::COL_LIM))
              ? pgws_pkg::CFG_W'(pgws_pkg::COL_LIM) : cols_q;

  // captured item, walker, clear counter
  logic [1:0]                  op_q, kind_q;
  logic [RW-1:0]               row_q, col_q, wrow_q, wcol_q;
  logic [pgws_pkg::GAIN_W-1:0] rnd_q;
  logic [AW-1:0]               clr_q;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
    return AW'(r * pgws_pkg::MAX_COLS + c);
  endfunction

  // neighbor scan
  logic signed [pgws_pkg::OFS_W-1:0] dr_q, dc_q;
  logic signed [7:0] nr, nc;
  logic [AW-1:0]     nb_addr, self_addr;

  assign nr = $signed({2'b00, wrow_q}) + 8'(dr_q);
  assign nc = $signed({2'b00, wcol_q}) + 8'(dc_q);
  assign nb_addr   = cell_addr(nr[RW-1:0], nc[RW-1:0]);
  assign self_addr = cell_addr(wrow_q, wcol_q);

  assign stat_o.nb_valid = !(dr_q == 0 && dc_q == 0) && !nr[7] && !nc[7]
                           && (nr[6:0] < ar) && (nc[6:0] < ac);
  assign stat_o.nb_last  = (dr_q == RMAX) && (dc_q == RMAX);
  assign stat_o.clr_done = (clr_q == AW'(pgws_pkg::DEPTH - 1));

  // RAMs
  logic          k_we, p_we;
  logic [AW-1:0] k_waddr, p_waddr, raddr;
  logic [1:0]    k_wdata, k_rdata;
  logic [pgws_pkg::LVL_W-1:0] p_wdata, p_rdata;

  assign raddr = cmd_i.self_read ? self_addr : nb_addr;

  pgws_ram #(.WIDTH(2), .DEPTH(pgws_pkg::DEPTH)) u_kind (
    .clk_i(clk_i), .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(raddr), .rdata_o(k_rdata)
  );

  pgws_ram #(.WIDTH(pgws_pkg::LVL_W), .DEPTH(pgws_pkg::DEPTH)) u_pher (
    .clk_i(clk_i), .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(raddr), .rdata_o(p_rdata)
  );

  assign stat_o.is_wall = (k_rdata == pgws_pkg::KIND_WALL);

  // deposit: level + ((1 - level) * gain) >> 16
  logic [pgws_pkg::LVL_W-1:0]  lvl_q, new_lvl;
  logic [pgws_pkg::PROD_W-1:0] prod_q;
  logic [pgws_pkg::WGT_W-1:0]  head, new_wgt;

  assign head    = pgws_pkg::WGT_W'(1 << pgws_pkg::LVL_W) - {1'b0, p_rdata};
  assign new_lvl = lvl_q + prod_q[pgws_pkg::GAIN_W +: pgws_pkg::LVL_W];
  assign new_wgt = pgws_pkg::WGT_W'(1 << pgws_pkg::LVL_W) - {1'b0, new_lvl};

  // weights, running sums, pick
  logic [pgws_pkg::WGT_W-1:0] w_q [pgws_pkg::NBR_MAX];
  logic [RW-1:0]              wr_q [pgws_pkg::NBR_MAX];
  logic [RW-1:0]              wc_q [pgws_pkg::NBR_MAX];
  logic [pgws_pkg::NBR_CW-1:0] n_q, sel_q;
  logic [pgws_pkg::TOT_W-1:0] total_q, acc_q, acc_d;
  logic [pgws_pkg::RT_W-1:0]  rt_q;
  logic [RW-1:0]              prow_q, pcol_q;
  logic [1:0]                 status_q;
  logic                       place_ok;

  assign acc_d  = acc_q + pgws_pkg::TOT_W'(w_q[sel_q[pgws_pkg::NBR_IW-1:0]]);
  assign stat_o.sel_hit = ({acc_d, 16'h0000} >= rt_q)
                          || (sel_q == n_q - 1'b1);
  assign stat_o.n_zero  = (n_q == '0);

  assign place_ok = ({1'b0, row_q} < ar) && ({1'b0, col_q} < ac);

  // map write ports
  always_comb begin
    k_we = 1'b0; k_waddr = clr_q; k_wdata = pgws_pkg::KIND_FREE;
    if (cmd_i.clr_step) begin
      k_we = 1'b1;
    end else if (cmd_i.exec && op_q == pgws_pkg::OP_WRITE) begin
      k_we    = ({1'b0, row_q} < 7'(pgws_pkg::MAX_ROWS))
                && ({1'b0, col_q} < 7'(pgws_pkg::MAX_COLS));
      k_waddr = cell_addr(row_q, col_q);
      k_wdata = kind_q;
    end else if (cmd_i.exec && op_q == pgws_pkg::OP_PLACE) begin
      k_we    = place_ok;
      k_waddr = cell_addr(row_q, col_q);
      k_wdata = pgws_pkg::KIND_ROBOT;
    end else if (cmd_i.mark_old) begin
      k_we    = 1'b1;
      k_waddr = self_addr;
      k_wdata = pgws_pkg::KIND_VISITED;
    end else if (cmd_i.mark_new) begin
      k_we    = 1'b1;
      k_waddr = cell_addr(prow_q, pcol_q);
      k_wdata = pgws_pkg::KIND_ROBOT;
    end
  end

  always_comb begin
    p_we    = cmd_i.clr_step || cmd_i.nb_write || cmd_i.self_write;
    p_waddr = cmd_i.clr_step ? clr_q : (cmd_i.self_write ? self_addr : nb_addr);
    p_wdata = cmd_i.clr_step ? '0 : new_lvl;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      wrow_q   <= '0;
      wcol_q   <= '0;
      dr_q     <= RMIN;
      dc_q     <= RMIN;
      n_q      <= '0;
      sel_q    <= '0;
      status_q <= pgws_pkg::ST_DONE;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) begin
        dr_q <= RMIN;
        dc_q <= RMIN;
        n_q  <= '0;
      end
      if (cmd_i.nb_next) begin
        if (dc_q == RMAX) begin
          dc_q <= RMIN;
          dr_q <= dr_q + 1'b1;
        end else begin
          dc_q <= dc_q + 1'b1;
        end
      end
      if (cmd_i.nb_write) n_q <= n_q + 1'b1;
      if (cmd_i.mul_rt) sel_q <= '0;
      if (cmd_i.sel_step && !stat_o.sel_hit) sel_q <= sel_q + 1'b1;
      if (cmd_i.exec) begin
        status_q <= pgws_pkg::ST_DONE;
        if (op_q == pgws_pkg::OP_PLACE && place_ok) begin
          wrow_q <= row_q;
          wcol_q <= col_q;
        end
      end
      if (cmd_i.self_write) status_q <= stat_o.n_zero ? pgws_pkg::ST_BLOCKED : pgws_pkg::ST_MOVED;
      if (cmd_i.mark_new) begin
        wrow_q <= prow_q;
        wcol_q <= pcol_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_op_i;
      row_q  <= in_row_i;
      col_q  <= in_col_i;
      kind_q <= in_kind_i;
      rnd_q  <= in_rnd_i;
      total_q <= '0;
    end
    if (cmd_i.mul) begin
      lvl_q  <= p_rdata;
      prod_q <= head * (cmd_i.mul_self ? sgain_q : ngain_q);
    end
    if (cmd_i.nb_write) begin
      w_q[n_q[pgws_pkg::NBR_IW-1:0]]  <= new_wgt;
      wr_q[n_q[pgws_pkg::NBR_IW-1:0]] <= nr[RW-1:0];
      wc_q[n_q[pgws_pkg::NBR_IW-1:0]] <= nc[RW-1:0];
      total_q <= total_q + pgws_pkg::TOT_W'(new_wgt);
    end
    if (cmd_i.mul_rt) begin
      rt_q  <= rnd_q * total_q;
      acc_q <= '0;
    end
    if (cmd_i.sel_step) begin
      acc_q <= acc_d;
      if (stat_o.sel_hit) begin
        prow_q <= wr_q[sel_q[pgws_pkg::NBR_IW-1:0]];
        pcol_q <= wc_q[sel_q[pgws_pkg::NBR_IW-1:0]];
      end
    end
    if (cmd_i.out_load) begin
      pos_row_o <= wrow_q;
      pos_col_o <= wcol_q;
      status_o  <= status_q;
    end
  end

`ifndef ASSERT_OFF
  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.nb_write |-> (n_q < pgws_pkg::NBR_CW'(pgws_pkg::NBR_MAX)))
    else $error("neighbor count overflow");
  a_sel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sel_step |-> (sel_q < n_q))
    else $error("selection past stored neighbors");
  a_walker_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_new |=> (({1'b0, wrow_q} < ar) && ({1'b0, wcol_q} < ac)))
    else $error("walker moved outside grid");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - pheromone grid walker checker
// Drives map writes, placements, moves and nops with random idling on both
// stream sides, predicts every output word from a local copy of the grid,
// the pheromone levels and the registers, and compares field by field.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    pgws_pkg::op_e op;
    logic [5:0]    row;
    logic [5:0]    col;
    logic [1:0]    kind;
    logic [15:0]   rnd;
  } cmd_word_t;

  // lowest bits first on the bus: row, col, status
  typedef struct packed {
    pgws_pkg::status_e st;
    logic [5:0]        col;
    logic [5:0]        row;
  } pos_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  pheromone_grid_walk_step_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [1:0]  kind_grid [pgws_pkg::DEPTH];
  logic [15:0] level_grid [pgws_pkg::DEPTH];
  logic [5:0]  walk_r, walk_c;
  int unsigned rows_reg, cols_reg;
  logic [15:0] ngain_reg, sgain_reg;

  cmd_word_t   pending_cmds [$];
  pos_word_t   expected_pos [$];
  int          send_idle_pct = 0, recv_idle_pct = 0;
  int          mismatches = 0;

  function automatic logic [15:0] deposit(logic [15:0] lvl, logic [15:0] gain);
    logic [33:0] prod;
    prod = (34'd65536 - lvl) * gain;
    return lvl + prod[31:16];
  endfunction

  function automatic int unsigned lim(int unsigned v);
    return (v > 64) ? 64 : v;
  endfunction

  task automatic predict_walk(input cmd_word_t c);
    int                ar, ac, nr, nc, n, pick;
    int                idx_l [8];
    logic [5:0]        r_l [8], c_l [8];
    logic [16:0]       w_l [8];
    logic [63:0]       total, acc;
    int                self_idx;
    pgws_pkg::status_e st;
    ar = lim(rows_reg);
    ac = lim(cols_reg);
    st = pgws_pkg::ST_DONE;
    n = 0;
    total = 0;
    acc = 0;
    case (c.op)
      pgws_pkg::OP_WRITE: kind_grid[{c.row, c.col}] = c.kind;
      pgws_pkg::OP_PLACE: begin
        if (c.row < ar && c.col < ac) begin
          walk_r = c.row;
          walk_c = c.col;
          kind_grid[{c.row, c.col}] = pgws_pkg::KIND_ROBOT;
        end
      end
      pgws_pkg::OP_MOVE: begin
        self_idx = int'({walk_r, walk_c});
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = int'(walk_r) + dr;
            nc = int'(walk_c) + dc;
            if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < ar && nc < ac &&
                kind_grid[nr * 64 + nc] != pgws_pkg::KIND_WALL) begin
              idx_l[n] = nr * 64 + nc;
              level_grid[idx_l[n]] = deposit(level_grid[idx_l[n]], ngain_reg);
              r_l[n] = 6'(nr);
              c_l[n] = 6'(nc);
              w_l[n] = 17'd65536 - level_grid[idx_l[n]];
              total += w_l[n];
              n++;
            end
          end
        end
        level_grid[self_idx] = deposit(level_grid[self_idx], sgain_reg);
        if (n == 0) begin
          st = pgws_pkg::ST_BLOCKED;
        end else begin
          pick = n - 1;
          for (int i = 0; i < n; i++) begin
            acc += w_l[i];
            if ((acc << 16) >= c.rnd * total) begin
              pick = i;
              break;
            end
          end
          kind_grid[self_idx] = pgws_pkg::KIND_VISITED;
          kind_grid[idx_l[pick]] = pgws_pkg::KIND_ROBOT;
          walk_r = r_l[pick];
          walk_c = c_l[pick];
          st = pgws_pkg::ST_MOVED;
        end
      end
      default: ;
    endcase
    expected_pos.push_back('{st, walk_c, walk_r});
  endtask

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_walk(pending_cmds.pop_front());
    end
    if ((!s_axis_tvalid || s_axis_tready) && pending_cmds.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= pending_cmds[0].op;
      s_axis_tdata  <= {2'b0, pending_cmds[0].rnd, pending_cmds[0].kind,
                        pending_cmds[0].col, pending_cmds[0].row};
    end else if (!s_axis_tvalid || s_axis_tready) begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pos_word_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[13:0];
      if (expected_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        want = expected_pos.pop_front();
        if (got.row !== want.row || got.col !== want.col || got.st !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp row %0d col %0d st %0d, got row %0d col %0d st %0d",
                     want.row, want.col, want.st, got.row, got.col, got.st);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic queue_cmd(pgws_pkg::op_e op, int r, int c, int k, int rnd);
    cmd_word_t w;
    w.op = op;
    w.row = 6'(r);
    w.col = 6'(c);
    w.kind = 2'(k);
    w.rnd = 16'(rnd);
    pending_cmds.push_back(w);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pgws_pkg::REG_ROWS:  rows_reg  = val[6:0];
      pgws_pkg::REG_COLS:  cols_reg  = val[6:0];
      pgws_pkg::REG_NGAIN: ngain_reg = val;
      pgws_pkg::REG_SGAIN: sgain_reg = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_cmds.size() > 0 || expected_pos.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // random burst: mostly moves, some map edits, placements and nops
  task automatic random_burst(int count, int ar, int ac);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 8)
        queue_cmd(pgws_pkg::OP_PLACE, $urandom_range(ar + 1), $urandom_range(ac + 1), 0,
                  $urandom);
      else if (sel < 20)
        queue_cmd(pgws_pkg::OP_WRITE, $urandom_range(63), $urandom_range(63),
                  $urandom_range(3), $urandom);
      else if (sel < 23)
        queue_cmd(pgws_pkg::OP_NOP, $urandom_range(63), $urandom_range(63),
                  $urandom_range(3), $urandom);
      else
        queue_cmd(pgws_pkg::OP_MOVE, $urandom_range(63), $urandom_range(63),
                  $urandom_range(3), (sel & 1) ? $urandom : $urandom_range(3) * 21845);
    end
  endtask

  initial begin
    for (int i = 0; i < pgws_pkg::DEPTH; i++) begin
      kind_grid[i] = pgws_pkg::KIND_FREE;
      level_grid[i] = '0;
    end
    walk_r = '0;
    walk_c = '0;
    rows_reg = 64;
    cols_reg = 64;
    ngain_reg = 16'd14299;
    sgain_reg = 16'd42598;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset gains, corners, walls, blocked walker, extremes
    send_idle_pct = 31;
    recv_idle_pct = 75;
    queue_cmd(pgws_pkg::OP_MOVE, 0, 0, 0, 0);
    queue_cmd(pgws_pkg::OP_MOVE, 0, 0, 0, 16'hFFFF);
    queue_cmd(pgws_pkg::OP_PLACE, 63, 63, 0, 0);
    queue_cmd(pgws_pkg::OP_MOVE, 63, 63, 3, 16'h8000);
    queue_cmd(pgws_pkg::OP_WRITE, 63, 63, 3, 16'hFFFF);
    queue_cmd(pgws_pkg::OP_NOP, 63, 63, 3, 16'hFFFF);
    queue_cmd(pgws_pkg::OP_PLACE, 10, 10, 0, 0);
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0)
          queue_cmd(pgws_pkg::OP_WRITE, 10 + dr, 10 + dc, pgws_pkg::KIND_WALL, 0);
    queue_cmd(pgws_pkg::OP_MOVE, 0, 0, 0, 1234);
    queue_cmd(pgws_pkg::OP_WRITE, 11, 11, pgws_pkg::KIND_VISITED, 0);
    queue_cmd(pgws_pkg::OP_MOVE, 0, 0, 0, 0);
    queue_cmd(pgws_pkg::OP_MOVE, 0, 0, 0, 16'hFFFF);
    queue_cmd(pgws_pkg::OP_PLACE, 5, 5, 0, 0);
    random_burst(450, 64, 64);
    drain();

    // tiny grid, extreme gains
    write_reg(pgws_pkg::REG_ROWS, 3);
    write_reg(pgws_pkg::REG_COLS, 3);
    write_reg(pgws_pkg::REG_NGAIN, 16'hFFFF);
    write_reg(pgws_pkg::REG_SGAIN, 16'h0000);
    send_idle_pct = 75;
    recv_idle_pct = 31;
    queue_cmd(pgws_pkg::OP_PLACE, 3, 1, 0, 0);
    queue_cmd(pgws_pkg::OP_PLACE, 1, 1, 0, 0);
    random_burst(300, 3, 3);
    drain();

    // odd sizes, out-of-range register values, zero neighbor gain
    write_reg(pgws_pkg::REG_ROWS, 7'd127);
    write_reg(pgws_pkg::REG_COLS, 5);
    write_reg(pgws_pkg::REG_NGAIN, 0);
    write_reg(pgws_pkg::REG_SGAIN, 16'hFFFF);
    random_burst(250, 64, 5);
    drain();

    // empty grid, then back to wide
    write_reg(pgws_pkg::REG_ROWS, 0);
    queue_cmd(pgws_pkg::OP_PLACE, 0, 0, 0, 0);
    queue_cmd(pgws_pkg::OP_MOVE, 0, 0, 0, 100);
    drain();
    write_reg(pgws_pkg::REG_ROWS, 64);
    write_reg(pgws_pkg::REG_COLS, 64);
    write_reg(pgws_pkg::REG_NGAIN, 16'($urandom));
    write_reg(pgws_pkg::REG_SGAIN, 16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(440, 16, 16);
    drain();

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
